### rtl/mzcv_pkg.sv
`timescale 1ns / 1ps
// mzcv_pkg: shared types, constants and codes of the mask zone contamination voter
// no dependencies; used by mzcv_ctrl, mzcv_datapath and the top level
package mzcv_pkg;

  // geometry and window sizing
  localparam int COORD_BITS    = 12;
  localparam int WINDOW_DEPTH  = 64;
  localparam int ADDR_BITS     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_BITS      = $clog2(WINDOW_DEPTH + 1);
  localparam int CFG_CNT_BITS  = 7;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CMP_BITS      = (CNT_BITS > CFG_CNT_BITS) ? CNT_BITS : CFG_CNT_BITS;
  localparam int SQ_BITS       = 2 * COORD_BITS;

  // configuration reset values
  localparam logic [COORD_BITS-1:0]   CENTER_X_RST     = COORD_BITS'(885);
  localparam logic [COORD_BITS-1:0]   CENTER_Y_RST     = COORD_BITS'(430);
  localparam logic [COORD_BITS-1:0]   MASK_RADIUS_RST  = COORD_BITS'(200);
  localparam logic [CFG_CNT_BITS-1:0] HEAVY_COUNT_RST  = CFG_CNT_BITS'(3);
  localparam logic [CFG_CNT_BITS-1:0] SLIGHT_COUNT_RST = CFG_CNT_BITS'(5);
  localparam logic [CFG_CNT_BITS-1:0] RUN_MIN_RST      = CFG_CNT_BITS'(3);
  localparam logic [CFG_CNT_BITS-1:0] WINDOW_LEN_RST   = CFG_CNT_BITS'(30);

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_MASK_RADIUS  = 3'd2,
    CFG_HEAVY_COUNT  = 3'd3,
    CFG_SLIGHT_COUNT = 3'd4,
    CFG_RUN_MIN      = 3'd5,
    CFG_WINDOW_LEN   = 3'd6
  } cfg_index_t;

  // frame verdict codes
  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_OUTSIDE = 2'd1,
    VERDICT_INSIDE  = 2'd2
  } verdict_t;

  // window level codes
  typedef enum logic [1:0] {
    LEVEL_CLEAN  = 2'd0,
    LEVEL_SLIGHT = 2'd1,
    LEVEL_HEAVY  = 2'd2
  } level_t;

  // reason codes
  typedef enum logic [2:0] {
    REASON_CLEAN        = 3'd0,
    REASON_HEAVY_COUNT  = 3'd1,
    REASON_HEAVY_RUN    = 3'd2,
    REASON_SLIGHT_COUNT = 3'd3,
    REASON_SLIGHT_RUN   = 3'd4
  } reason_t;

  // input payload
  typedef struct packed {
    logic                  box_present;
    logic [COORD_BITS-1:0] left_x;
    logic [COORD_BITS-1:0] top_y;
    logic [COORD_BITS-1:0] right_x;
    logic [COORD_BITS-1:0] bottom_y;
    logic                  last_in_frame;
  } in_t;

  // result payload
  typedef struct packed {
    logic [1:0] frame_verdict;
    logic [1:0] level;
    logic [2:0] reason;
  } out_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_TEST,
    ST_WRITE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic square;
    logic test;
    logic write;
    logic setup;
    logic scan_read;
    logic decide;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_last;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

### rtl/mzcv_ctrl.sv
`timescale 1ns / 1ps
// mzcv_ctrl: sequencing state machine of the voter
// depends on mzcv_pkg (state, command and status types)
module mzcv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mzcv_pkg::status_t status,
  output mzcv_pkg::cmd_t    cmd
);

  mzcv_pkg::state_t state;
  mzcv_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mzcv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      mzcv_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = mzcv_pkg::ST_SQUARE;
        end
      end
      mzcv_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = mzcv_pkg::ST_TEST;
      end
      mzcv_pkg::ST_TEST: begin
        cmd.test   = 1'b1;
        state_next = status.item_last ? mzcv_pkg::ST_WRITE : mzcv_pkg::ST_IDLE;
      end
      mzcv_pkg::ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = mzcv_pkg::ST_SETUP;
      end
      mzcv_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = mzcv_pkg::ST_SCAN;
      end
      mzcv_pkg::ST_SCAN: begin
        cmd.scan_read = 1'b1;
        if (status.scan_last) begin
          state_next = mzcv_pkg::ST_DRAIN;
        end
      end
      mzcv_pkg::ST_DRAIN: begin
        state_next = mzcv_pkg::ST_DECIDE;
      end
      mzcv_pkg::ST_DECIDE: begin
        if (status.out_free) begin
          cmd.decide = 1'b1;
          state_next = mzcv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mzcv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/mzcv_datapath.sv
`timescale 1ns / 1ps
// mzcv_datapath: config registers, center test, verdict window store, scan and output register
// depends on mzcv_pkg (payload, command, status types and codes)
module mzcv_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mzcv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mzcv_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  mzcv_pkg::in_t                       in_data,
  input  mzcv_pkg::cmd_t                      cmd,
  output mzcv_pkg::status_t                   status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mzcv_pkg::out_t                      out_data
);

  localparam int CB = mzcv_pkg::COORD_BITS;
  localparam int AB = mzcv_pkg::ADDR_BITS;
  localparam int NB = mzcv_pkg::CNT_BITS;
  localparam int KB = mzcv_pkg::CFG_CNT_BITS;
  localparam int MB = mzcv_pkg::CMP_BITS;
  localparam int SB = mzcv_pkg::SQ_BITS;
  localparam int DEPTH = mzcv_pkg::WINDOW_DEPTH;

  // configuration
  logic [CB-1:0] center_x, center_y, mask_radius;
  logic [KB-1:0] heavy_count_min, slight_count_min, run_min, window_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x         <= mzcv_pkg::CENTER_X_RST;
      center_y         <= mzcv_pkg::CENTER_Y_RST;
      mask_radius      <= mzcv_pkg::MASK_RADIUS_RST;
      heavy_count_min  <= mzcv_pkg::HEAVY_COUNT_RST;
      slight_count_min <= mzcv_pkg::SLIGHT_COUNT_RST;
      run_min          <= mzcv_pkg::RUN_MIN_RST;
      window_length    <= mzcv_pkg::WINDOW_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mzcv_pkg::CFG_CENTER_X:     center_x         <= cfg_data[CB-1:0];
        mzcv_pkg::CFG_CENTER_Y:     center_y         <= cfg_data[CB-1:0];
        mzcv_pkg::CFG_MASK_RADIUS:  mask_radius      <= cfg_data[CB-1:0];
        mzcv_pkg::CFG_HEAVY_COUNT:  heavy_count_min  <= cfg_data[KB-1:0];
        mzcv_pkg::CFG_SLIGHT_COUNT: slight_count_min <= cfg_data[KB-1:0];
        mzcv_pkg::CFG_RUN_MIN:      run_min          <= cfg_data[KB-1:0];
        mzcv_pkg::CFG_WINDOW_LEN:   window_length    <= cfg_data[KB-1:0];
        default: ;
      endcase
    end
  end

  // item register
  mzcv_pkg::in_t item;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
  end

  assign status.item_last = item.last_in_frame;

  // center and distance from the mask center
  logic [CB:0]   sum_x, sum_y;
  logic [CB-1:0] cx, cy, adx, ady;

  always_comb begin
    sum_x = {1'b0, item.left_x} + {1'b0, item.right_x};
    sum_y = {1'b0, item.top_y} + {1'b0, item.bottom_y};
    cx    = sum_x[CB:1];
    cy    = sum_y[CB:1];
    adx   = (cx >= center_x) ? (cx - center_x) : (center_x - cx);
    ady   = (cy >= center_y) ? (cy - center_y) : (center_y - cy);
  end

  // squares, registered before the compare
  logic [SB-1:0] sq_x, sq_y, sq_r;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_x <= SB'(adx) * SB'(adx);
      sq_y <= SB'(ady) * SB'(ady);
      sq_r <= SB'(mask_radius) * SB'(mask_radius);
    end
  end

  logic inside_hit;
  assign inside_hit = ({1'b0, sq_x} + {1'b0, sq_y}) <= {1'b0, sq_r};

  // per-frame flags and window bookkeeping
  logic          inside_seen, outside_seen;
  logic [AB-1:0] write_slot;
  logic [NB-1:0] fill_count;
  logic [1:0]    verdict;
  logic [1:0]    frame_verdict;

  always_comb begin
    if (inside_seen) begin
      verdict = mzcv_pkg::VERDICT_INSIDE;
    end else if (outside_seen) begin
      verdict = mzcv_pkg::VERDICT_OUTSIDE;
    end else begin
      verdict = mzcv_pkg::VERDICT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_seen  <= 1'b0;
      outside_seen <= 1'b0;
      write_slot   <= '0;
      fill_count   <= '0;
    end else if (cmd.test && item.box_present) begin
      if (inside_hit) begin
        inside_seen <= 1'b1;
      end else begin
        outside_seen <= 1'b1;
      end
    end else if (cmd.write) begin
      inside_seen  <= 1'b0;
      outside_seen <= 1'b0;
      write_slot   <= (write_slot == AB'(DEPTH - 1)) ? '0 : write_slot + AB'(1);
      if (fill_count != NB'(DEPTH)) begin
        fill_count <= fill_count + NB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      frame_verdict <= verdict;
    end
  end

  // verdict window store
  logic [1:0]    window_mem [DEPTH];
  logic [AB-1:0] rd_addr;
  logic [1:0]    rd_data;
  logic          rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      window_mem[write_slot] <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_read) begin
      rd_data <= window_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_read;
    end
  end

  // scan span: most recent min(fill, clamped length) verdicts
  logic [MB-1:0] len_clamped;
  logic [NB-1:0] span;
  logic [NB-1:0] scan_len;
  logic [NB-1:0] scan_idx;
  logic [AB-1:0] scan_start;
  logic [AB:0]   start_calc;
  logic [AB:0]   addr_calc;

  always_comb begin
    if (window_length == '0) begin
      len_clamped = MB'(1);
    end else if (MB'(window_length) > MB'(DEPTH)) begin
      len_clamped = MB'(DEPTH);
    end else begin
      len_clamped = MB'(window_length);
    end
    span = (MB'(fill_count) < len_clamped) ? fill_count : NB'(len_clamped);
    if ((AB + 1)'(write_slot) >= (AB + 1)'(span)) begin
      start_calc = (AB + 1)'(write_slot) - (AB + 1)'(span);
    end else begin
      start_calc = (AB + 1)'(write_slot) + (AB + 1)'(DEPTH) - (AB + 1)'(span);
    end
    addr_calc = (AB + 1)'(scan_start) + (AB + 1)'(scan_idx);
    if (addr_calc >= (AB + 1)'(DEPTH)) begin
      addr_calc = addr_calc - (AB + 1)'(DEPTH);
    end
    rd_addr = addr_calc[AB-1:0];
  end

  assign status.scan_last = (scan_idx == scan_len - NB'(1));

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      scan_len   <= span;
      scan_start <= start_calc[AB-1:0];
      scan_idx   <= '0;
    end else if (cmd.scan_read) begin
      scan_idx <= scan_idx + NB'(1);
    end
  end

  // level counts and longest runs
  logic [NB-1:0] cnt2, cnt1, run2, max2, runc, maxc;
  logic [NB-1:0] run2_inc, runc_inc;

  assign run2_inc = run2 + NB'(1);
  assign runc_inc = runc + NB'(1);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cnt2 <= '0;
      cnt1 <= '0;
      run2 <= '0;
      max2 <= '0;
      runc <= '0;
      maxc <= '0;
    end else if (rd_valid) begin
      if (rd_data == mzcv_pkg::VERDICT_INSIDE) begin
        cnt2 <= cnt2 + NB'(1);
        run2 <= run2_inc;
        if (run2_inc > max2) begin
          max2 <= run2_inc;
        end
      end else begin
        run2 <= '0;
      end
      if (rd_data == mzcv_pkg::VERDICT_OUTSIDE) begin
        cnt1 <= cnt1 + NB'(1);
      end
      if (rd_data != mzcv_pkg::VERDICT_NONE) begin
        runc <= runc_inc;
        if (runc_inc > maxc) begin
          maxc <= runc_inc;
        end
      end else begin
        runc <= '0;
      end
    end
  end

  // decision
  logic [1:0] level;
  logic [2:0] reason;

  always_comb begin
    if (MB'(cnt2) >= MB'(heavy_count_min)) begin
      level  = mzcv_pkg::LEVEL_HEAVY;
      reason = mzcv_pkg::REASON_HEAVY_COUNT;
    end else if (MB'(max2) >= MB'(run_min)) begin
      level  = mzcv_pkg::LEVEL_HEAVY;
      reason = mzcv_pkg::REASON_HEAVY_RUN;
    end else if (MB'(cnt1) >= MB'(slight_count_min)) begin
      level  = mzcv_pkg::LEVEL_SLIGHT;
      reason = mzcv_pkg::REASON_SLIGHT_COUNT;
    end else if (MB'(maxc) >= MB'(run_min)) begin
      level  = mzcv_pkg::LEVEL_SLIGHT;
      reason = mzcv_pkg::REASON_SLIGHT_RUN;
    end else begin
      level  = mzcv_pkg::LEVEL_CLEAN;
      reason = mzcv_pkg::REASON_CLEAN;
    end
  end

  // output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.decide) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_data.frame_verdict <= frame_verdict;
      out_data.level         <= level;
      out_data.reason        <= reason;
    end
  end

endmodule

### rtl/mask_zone_contamination_voter.sv
`timescale 1ns / 1ps
// mask_zone_contamination_voter: top level, joins controller and datapath
// depends on mzcv_pkg, mzcv_ctrl and mzcv_datapath
//
// Takes detection boxes one transfer per box, grouped into frames by
// last_in_frame; an empty frame is a single transfer with box_present low.
// Each box center is tested against a circular mask (squared distance against
// squared radius), and at the end of each frame the frame verdict is written
// into a 64-entry window store. The most recent min(frames seen, window_length)
// verdicts are then read back one per cycle to build the level counts and the
// longest runs, and one result (frame verdict, level, reason) is produced per
// frame. An item that does not end a frame passes through capture, square and
// compare; an item that ends a frame goes on through write, setup, a scan of 1
// to 64 verdicts through the single read port of the window store, drain and
// decide. A finished result sits in an output register, so the next box
// is taken while it waits; if that result is still not taken when the next
// frame's decision is due, the block holds at the decision with the box input
// stalled until the output register frees up. Configuration is
// written through cfg_valid/cfg_ready, always ready, and should only be
// written while the block is idle. Window entries never written since reset
// are never scanned, so the store needs no clearing pass after reset.
module mask_zone_contamination_voter (
  input  logic                                clk,
  input  logic                                rst,
  // box input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mzcv_pkg::in_t                       in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output mzcv_pkg::out_t                      out_data,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mzcv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mzcv_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // command and status between sequencer and datapath
  mzcv_pkg::cmd_t    cmd;
  mzcv_pkg::status_t status;

  // configuration registers take a write in any cycle
  assign cfg_ready = 1'b1;

  mzcv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mzcv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // an accepted box keeps the input stalled while it is processed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  // a result is only loaded when the output register is free
  a_decide_free: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending transfer");

  // a new result raises out_valid in the next cycle
  a_decide_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> out_valid)
    else $error("result loaded but not presented");

endmodule

### tb/sv/mzcv_checker.sv
`timescale 1ns / 1ps
// mzcv_checker: watches the box, result and register write channels of the voter,
// keeps its own copy of the mask, the verdict history and the frame flags, and
// compares every delivered result with its prediction; depends on mzcv_pkg
module mzcv_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  mzcv_pkg::in_t                       in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  mzcv_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [mzcv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mzcv_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  results_checked,
  output logic [4:0]                          reasons_seen
);

  localparam int MAX_REPORTS = 10;
  localparam int CB = mzcv_pkg::COORD_BITS;
  localparam int KB = mzcv_pkg::CFG_CNT_BITS;
  localparam int WD = mzcv_pkg::WINDOW_DEPTH;

  // predictor copy of the registers
  logic [CB-1:0] mask_cx, mask_cy, mask_r;
  logic [KB-1:0] heavy_min, slight_min, run_thresh, win_len;

  // predictor copy of the verdict history and frame flags
  mzcv_pkg::verdict_t verdict_history [WD];
  int                 write_pos;
  int                 filled;
  logic               saw_inside, saw_outside;

  // expected results, oldest first
  mzcv_pkg::out_t frame_results [$];
  int             mismatches = 0;
  int             checked = 0;
  logic [4:0]     reason_hits = '0;

  always @(posedge clk) begin : track
    int                 cx, cy, dx, dy;
    int                 eff_len, span, base;
    int                 cnt_in, cnt_out, run_in, best_in, run_any, best_any;
    mzcv_pkg::verdict_t v, frame_v;
    mzcv_pkg::out_t     want;
    if (rst) begin
      mask_cx     = mzcv_pkg::CENTER_X_RST;
      mask_cy     = mzcv_pkg::CENTER_Y_RST;
      mask_r      = mzcv_pkg::MASK_RADIUS_RST;
      heavy_min   = mzcv_pkg::HEAVY_COUNT_RST;
      slight_min  = mzcv_pkg::SLIGHT_COUNT_RST;
      run_thresh  = mzcv_pkg::RUN_MIN_RST;
      win_len     = mzcv_pkg::WINDOW_LEN_RST;
      write_pos   = 0;
      filled      = 0;
      saw_inside  = 1'b0;
      saw_outside = 1'b0;
      frame_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (mzcv_pkg::cfg_index_t'(cfg_index))
          mzcv_pkg::CFG_CENTER_X:     mask_cx    = cfg_data;
          mzcv_pkg::CFG_CENTER_Y:     mask_cy    = cfg_data;
          mzcv_pkg::CFG_MASK_RADIUS:  mask_r     = cfg_data;
          mzcv_pkg::CFG_HEAVY_COUNT:  heavy_min  = cfg_data[KB-1:0];
          mzcv_pkg::CFG_SLIGHT_COUNT: slight_min = cfg_data[KB-1:0];
          mzcv_pkg::CFG_RUN_MIN:      run_thresh = cfg_data[KB-1:0];
          mzcv_pkg::CFG_WINDOW_LEN:   win_len    = cfg_data[KB-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (in_data.box_present) begin
          cx = (int'(in_data.left_x) + int'(in_data.right_x)) >> 1;
          cy = (int'(in_data.top_y) + int'(in_data.bottom_y)) >> 1;
          dx = cx - int'(mask_cx);
          dy = cy - int'(mask_cy);
          if (dx * dx + dy * dy <= int'(mask_r) * int'(mask_r)) saw_inside = 1'b1;
          else saw_outside = 1'b1;
        end
        if (in_data.last_in_frame) begin
          if (saw_inside) frame_v = mzcv_pkg::VERDICT_INSIDE;
          else if (saw_outside) frame_v = mzcv_pkg::VERDICT_OUTSIDE;
          else frame_v = mzcv_pkg::VERDICT_NONE;
          saw_inside  = 1'b0;
          saw_outside = 1'b0;
          verdict_history[write_pos] = frame_v;
          write_pos = (write_pos + 1) % WD;
          if (filled < WD) filled++;

          // length 0 behaves as 1, anything past the store depth as the depth
          eff_len = (win_len == 0) ? 1 : ((win_len > WD) ? WD : int'(win_len));
          span = (filled < eff_len) ? filled : eff_len;
          base = write_pos + WD - span;
          cnt_in = 0; cnt_out = 0; run_in = 0; best_in = 0; run_any = 0; best_any = 0;
          for (int i = 0; i < span; i++) begin
            v = verdict_history[(base + i) % WD];
            if (v == mzcv_pkg::VERDICT_INSIDE) begin
              cnt_in++;
              run_in++;
              if (run_in > best_in) best_in = run_in;
            end else begin
              run_in = 0;
            end
            if (v == mzcv_pkg::VERDICT_OUTSIDE) cnt_out++;
            if (v != mzcv_pkg::VERDICT_NONE) begin
              run_any++;
              if (run_any > best_any) best_any = run_any;
            end else begin
              run_any = 0;
            end
          end

          want.frame_verdict = frame_v;
          if (cnt_in >= int'(heavy_min)) begin
            want.level  = mzcv_pkg::LEVEL_HEAVY;
            want.reason = mzcv_pkg::REASON_HEAVY_COUNT;
          end else if (best_in >= int'(run_thresh)) begin
            want.level  = mzcv_pkg::LEVEL_HEAVY;
            want.reason = mzcv_pkg::REASON_HEAVY_RUN;
          end else if (cnt_out >= int'(slight_min)) begin
            want.level  = mzcv_pkg::LEVEL_SLIGHT;
            want.reason = mzcv_pkg::REASON_SLIGHT_COUNT;
          end else if (best_any >= int'(run_thresh)) begin
            want.level  = mzcv_pkg::LEVEL_SLIGHT;
            want.reason = mzcv_pkg::REASON_SLIGHT_RUN;
          end else begin
            want.level  = mzcv_pkg::LEVEL_CLEAN;
            want.reason = mzcv_pkg::REASON_CLEAN;
          end
          frame_results.insert(frame_results.size(), want);
        end
      end

      if (out_valid && !out_stall) begin
        checked++;
        if (frame_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: got verdict %0d level %0d reason %0d with no frame pending",
                     checked, out_data.frame_verdict, out_data.level, out_data.reason);
        end else begin
          want = frame_results[0];
          frame_results.delete(0);
          reason_hits[want.reason] = 1'b1;
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: expected verdict %0d level %0d reason %0d, got %0d %0d %0d",
                       checked, want.frame_verdict, want.level, want.reason,
                       out_data.frame_verdict, out_data.level, out_data.reason);
          end
        end
      end
    end
    fail_count      <= mismatches;
    pending         <= frame_results.size();
    results_checked <= checked;
    reasons_seen    <= reason_hits;
  end

endmodule

### tb/sv/mask_zone_contamination_voter_tb.sv
`timescale 1ns / 1ps
// mask_zone_contamination_voter_tb: stimulus and verdict for the contamination voter
// drives boxes, register writes and result back-pressure; mzcv_checker does the checking
// depends on mzcv_pkg, mzcv_checker and the voter RTL
module mask_zone_contamination_voter_tb;

  localparam int CB            = mzcv_pkg::COORD_BITS;
  localparam int IB            = mzcv_pkg::CFG_IDX_BITS;
  localparam int DB            = mzcv_pkg::CFG_DATA_BITS;
  localparam int TARGET_ITEMS  = 1750;
  localparam int NUM_PHASES    = 10;
  localparam int CALM_ITEMS    = 150;
  // long receiver hold: enough for a result to wait and the next frame to stall the box input
  localparam int LONG_HOLD     = 600;
  // longest frame end is a 64-entry scan plus the write, setup, drain and decide steps; leave margin
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef enum int {FRAME_EMPTY, FRAME_FAR, FRAME_NEAR} frame_kind_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  mzcv_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  mzcv_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [IB-1:0]  cfg_index = '0;
  logic [DB-1:0]  cfg_data = '0;

  int         fail_count;
  int         pending;
  int         results_checked;
  logic [4:0] reasons_seen;

  int unsigned cycle_count = 0;
  int          items_sent = 0;   // boxes and frame ends, ignored empties not counted
  int          holds_asked = 0;
  int          gap_odds = 4;     // 0: sender never idles
  bit          calm = 1'b0;      // end of run: no idling on either side

  // stimulus view of the mask, kept in step with the register writes
  int mask_cx = int'(mzcv_pkg::CENTER_X_RST);
  int mask_cy = int'(mzcv_pkg::CENTER_Y_RST);
  int mask_r  = int'(mzcv_pkg::MASK_RADIUS_RST);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  mask_zone_contamination_voter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mzcv_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .reasons_seen    (reasons_seen)
  );

  function automatic logic [CB-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return CB'(v);
  endfunction

  function automatic mzcv_pkg::in_t box_at(input int l, input int t, input int r,
                                           input int b, input logic last);
    mzcv_pkg::in_t item;
    item.box_present   = 1'b1;
    item.left_x        = clamp_coord(l);
    item.top_y         = clamp_coord(t);
    item.right_x       = clamp_coord(r);
    item.bottom_y      = clamp_coord(b);
    item.last_in_frame = last;
    return item;
  endfunction

  // no box: coordinates are junk and must be ignored by the block
  function automatic mzcv_pkg::in_t empty_item(input logic last);
    mzcv_pkg::in_t item;
    item.box_present   = 1'b0;
    item.left_x        = CB'($urandom_range(0, 4095));
    item.top_y         = CB'($urandom_range(0, 4095));
    item.right_x       = CB'($urandom_range(0, 4095));
    item.bottom_y      = CB'($urandom_range(0, 4095));
    item.last_in_frame = last;
    return item;
  endfunction

  // near boxes put their center within one pixel beyond the radius of the mask
  // center, so both sides of the circle edge get hit
  function automatic mzcv_pkg::in_t make_box(input bit near, input logic last);
    int px, py, w, h;
    if (!near && $urandom_range(0, 1) == 1) begin
      // fully random corners, includes left past right
      return box_at($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095), last);
    end
    if (near) begin
      px = mask_cx + int'($urandom_range(0, 2 * mask_r + 2)) - mask_r - 1;
      py = mask_cy + int'($urandom_range(0, 2 * mask_r + 2)) - mask_r - 1;
      if ($urandom_range(0, 7) == 0) begin
        px = mask_cx;
        py = mask_cy;
      end
    end else begin
      px = $urandom_range(0, 4095);
      py = $urandom_range(0, 4095);
    end
    w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 40);
    h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 40);
    return box_at(px - w, py - h, px + w + int'($urandom_range(0, 1)),
                  py + h + int'($urandom_range(0, 1)), last);
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(9, 64);
      2: return $urandom_range(65, 127);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // one box-channel transfer, with an optional idle burst in front
  task automatic offer(input mzcv_pkg::in_t item);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (item.box_present || item.last_in_frame) items_sent++;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    int n_boxes;
    bit close_empty;
    if (kind == FRAME_EMPTY) begin
      offer(empty_item(1'b1));
      return;
    end
    n_boxes = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
    // now and then the frame is closed by a trailing no-box transfer
    close_empty = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < n_boxes; k++) begin
      if ($urandom_range(0, 7) == 0) offer(empty_item(1'b0));
      offer(make_box(kind == FRAME_NEAR && $urandom_range(0, 1) == 1,
                     !close_empty && k == n_boxes - 1));
    end
    if (close_empty) offer(empty_item(1'b1));
  endtask

  // quiet the input, wait for every pending result, then let the block finish
  // any box still in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input mzcv_pkg::cfg_index_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DB'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input int cx, input int cy, input int r, input int heavy,
                                input int slight, input int run_len, input int win);
    mask_cx = cx;
    mask_cy = cy;
    mask_r  = r;
    write_reg(mzcv_pkg::CFG_CENTER_X, cx);
    write_reg(mzcv_pkg::CFG_CENTER_Y, cy);
    write_reg(mzcv_pkg::CFG_MASK_RADIUS, r);
    write_reg(mzcv_pkg::CFG_HEAVY_COUNT, heavy);
    write_reg(mzcv_pkg::CFG_SLIGHT_COUNT, slight);
    write_reg(mzcv_pkg::CFG_RUN_MIN, run_len);
    write_reg(mzcv_pkg::CFG_WINDOW_LEN, win);
    cfg_valid <= 1'b0;
  endtask

  // random frames in streaks of one kind so that runs build up in the window;
  // squeeze adds the long receiver hold and one full drain pause
  task automatic run_phase(input int quota, input bit squeeze);
    frame_kind_t kind;
    int          streak, start;
    bit          held, paused;
    start  = items_sent;
    streak = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (items_sent - start < quota) begin
      if (items_sent >= TARGET_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (streak == 0) begin
        kind   = frame_kind_t'($urandom_range(0, 2));
        streak = ($urandom_range(0, 2) == 0) ? $urandom_range(3, 12) : 1;
        case ($urandom_range(0, 3))
          0: gap_odds = 0;
          1: gap_odds = 2;
          2: gap_odds = 5;
          default: gap_odds = 20;
        endcase
      end
      streak--;
      if (squeeze && !held && items_sent - start >= quota / 4) begin
        held = 1'b1;
        holds_asked++;
      end
      if (squeeze && !paused && items_sent - start >= 3 * quota / 4) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_frame(kind);
    end
  endtask

  // result side: random stall bursts, the long hold on request, none at the end
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done < holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        if (!calm) repeat ($urandom_range(0, 19)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int ox, oy, rr;
    int cx, cy, r, heavy, slight, run_len, win, quota;
    ox    = int'(mzcv_pkg::CENTER_X_RST);
    oy    = int'(mzcv_pkg::CENTER_Y_RST);
    rr    = int'(mzcv_pkg::MASK_RADIUS_RST);
    quota = TARGET_ITEMS / NUM_PHASES;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed frames under the reset settings
    gap_odds = 3;
    offer(empty_item(1'b1));                                   // empty frame
    offer(box_at(0, 0, 0, 0, 1'b1));                           // all-zero corners
    offer(box_at(4095, 4095, 4095, 4095, 1'b1));               // all-ones corners
    offer(empty_item(1'b0));                                   // no-box transfer mid frame
    offer(box_at(ox, oy, ox, oy, 1'b0));                       // dead center
    offer(box_at(0, 0, 4095, 4095, 1'b1));                     // outside, frame still inside
    offer(box_at(ox + rr - 1, oy - 1, ox + rr + 2, oy + 1, 1'b1)); // center on the edge
    offer(box_at(ox + rr + 1, oy, ox + rr + 1, oy, 1'b1));     // one pixel past the edge
    offer(box_at(ox, oy + rr, ox, oy + rr, 1'b1));
    offer(box_at(ox, oy + rr + 1, ox, oy + rr + 1, 1'b1));
    offer(box_at(ox - rr, oy, ox - rr, oy, 1'b1));
    offer(box_at(ox - rr - 1, oy, ox - rr - 1, oy, 1'b1));
    offer(box_at(ox, oy, ox + 1, oy + 1, 1'b0));               // frame closed by no-box
    offer(empty_item(1'b1));
    repeat (3) offer(empty_item(1'b1));
    run_phase(quota - items_sent, 1'b0);

    for (int phase = 1; phase < NUM_PHASES; phase++) begin
      settle();
      cx      = $urandom_range(0, 4095);
      cy      = $urandom_range(0, 4095);
      r       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
      heavy   = pick_threshold();
      slight  = pick_threshold();
      run_len = pick_threshold();
      win     = $urandom_range(1, 64);
      case (phase)
        1: begin
          cx = 0; cy = 0; r = 0;
          heavy = 0; slight = 0; run_len = 0; win = 1;
        end
        2: begin
          cx = 4095; cy = 4095; r = 4095;
          heavy = 64; slight = 64; run_len = 64; win = 64;
        end
        3: win = 4;
        4: win = 64;    // grows back: verdicts scanned out earlier come into view again
        5: win = 0;     // behaves as one
        6: begin
          win = 127;    // beyond the store depth
          heavy = 127;
        end
        default: ;
      endcase
      apply_settings(cx, cy, r, heavy, slight, run_len, win);
      run_phase(quota, phase == 4);
    end

    settle();
    $display("run covered %0d box and frame-end transfers over %0d register settings, %0d results",
             items_sent, NUM_PHASES, results_checked);
    $display("reasons reached (slight run down to clean) %b, %0d long result hold(s)",
             reasons_seen, holds_asked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
